@@ design/smsb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smsb_pkg
// Shared types and constants of the scaled mono sprite blitter.
// ----------------------------------------------------------------------------
package smsb_pkg;

    localparam int ADDR_W  = 17;
    localparam int COLOR_W = 16;
    localparam int SCALE_W = 4;
    localparam int NCOL_W  = 4;
    localparam int CNT_W   = 3;
    localparam int SW_W    = 9;
    localparam int SH_W    = 8;
    localparam int XOFF_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPRITE_WIDTH  = 3'd0,
        REG_SPRITE_HEIGHT = 3'd1,
        REG_SCALE_FACTOR  = 3'd2,
        REG_X_OFFSET      = 3'd3,
        REG_FG_COLOR      = 3'd4,
        REG_BG_COLOR      = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic pixel_bit;
        logic frame_start;
    } t_pixel_in;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_addr;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_write;
    } t_pixel_out;

    typedef struct packed {
        logic [SW_W-1:0]          sprite_width;
        logic [SH_W-1:0]          sprite_height;
        logic [SCALE_W-1:0]       scale_factor;
        logic signed [XOFF_W-1:0] x_offset;
        logic [COLOR_W-1:0]       fg_color;
        logic [COLOR_W-1:0]       bg_color;
    } t_cfg;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic [SCALE_W-1:0] scale;
        logic [NCOL_W-1:0]  ncols;
    } t_job;

endpackage
`default_nettype wire

@@ design/scaled_mono_sprite_blitter.sv @@
`default_nettype none
// The first write of a bit passes the front's placement register, the queue and
// the write sequencer's registers to the output register. Throughput: one write
// per cycle while i_out_ready allows; a bit gives k unclipped writes, scale
// squared when fully on screen. Bits with no writes are taken at one per cycle.
// Reset: synchronous, active low; clears counters, queue and output, and loads
// the register defaults.
// ----------------------------------------------------------------------------
// scaled_mono_sprite_blitter
// Expands a 1-bit sprite stream into scaled, clipped framebuffer writes.
// ----------------------------------------------------------------------------
module scaled_mono_sprite_blitter #(
    parameter int DEST_WIDTH    = 320,
    parameter int DEST_HEIGHT   = 240,
    parameter int MAX_SCALE     = 8,
    parameter int BOTTOM_MARGIN = 9
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [smsb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [smsb_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire smsb_pkg::t_pixel_in               i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output smsb_pkg::t_pixel_out                   o_out_data
);
    import smsb_pkg::*;

    t_cfg r_cfg;
    logic front_valid;
    t_job front_job;
    logic q_ready;
    logic q_valid;
    t_job q_job;
    logic q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_width  <= SW_W'(1);
            r_cfg.sprite_height <= SH_W'(1);
            r_cfg.scale_factor  <= SCALE_W'(1);
            r_cfg.x_offset      <= '0;
            r_cfg.fg_color      <= '1;
            r_cfg.bg_color      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SPRITE_WIDTH:  r_cfg.sprite_width  <= i_cfg_data[SW_W-1:0];
                REG_SPRITE_HEIGHT: r_cfg.sprite_height <= i_cfg_data[SH_W-1:0];
                REG_SCALE_FACTOR:  r_cfg.scale_factor  <= i_cfg_data[SCALE_W-1:0];
                REG_X_OFFSET:      r_cfg.x_offset      <= i_cfg_data[XOFF_W-1:0];
                REG_FG_COLOR:      r_cfg.fg_color      <= i_cfg_data[COLOR_W-1:0];
                REG_BG_COLOR:      r_cfg.bg_color      <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    smsb_front #(
        .DEST_WIDTH    (DEST_WIDTH),
        .DEST_HEIGHT   (DEST_HEIGHT),
        .MAX_SCALE     (MAX_SCALE),
        .BOTTOM_MARGIN (BOTTOM_MARGIN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (q_ready)
    );

    smsb_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (front_valid),
        .i_push_job (front_job),
        .o_ready    (q_ready),
        .o_valid    (q_valid),
        .o_job      (q_job),
        .i_pop      (q_pop)
    );

    smsb_back #(
        .DEST_WIDTH (DEST_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

@@ design/smsb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smsb_front
// Takes sprite bits, tracks the source position, places and clips the square.
// ----------------------------------------------------------------------------
module smsb_front #(
    parameter int DEST_WIDTH    = 320,
    parameter int DEST_HEIGHT   = 240,
    parameter int MAX_SCALE     = 8,
    parameter int BOTTOM_MARGIN = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire smsb_pkg::t_cfg    i_cfg,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire smsb_pkg::t_pixel_in i_in_data,
    output logic                   o_job_valid,
    output smsb_pkg::t_job         o_job,
    input  wire logic              i_job_ready
);
    import smsb_pkg::*;

    localparam int CW = 15;
    localparam logic signed [CW-1:0] W_M1 = CW'(DEST_WIDTH - 1);
    localparam logic signed [CW-1:0] H_S = CW'(DEST_HEIGHT);
    localparam logic [ADDR_W-1:0]    W_A = ADDR_W'(DEST_WIDTH);

    logic [SW_W-1:0]    r_col;
    logic [SH_W-1:0]    r_row;
    logic               r_done;
    logic               r_a_valid;
    logic               r_a_gen;
    logic signed [CW-1:0] r_a_y0;
    logic signed [CW-1:0] r_a_x0;
    logic [COLOR_W-1:0] r_a_color;
    logic [SCALE_W-1:0] r_a_scale;

    logic [SW_W-1:0]    eff_col;
    logic [SH_W-1:0]    eff_row;
    logic               eff_done;
    logic               active;
    logic [SCALE_W-1:0] s_sat;
    logic [CW-1:0]      hs;
    logic [CW-1:0]      rs;
    logic [CW-1:0]      cs;
    logic [CW-1:0]      xoff_ext;
    logic               accept;
    logic               a_adv;

    logic signed [CW-1:0] s_m1;
    logic signed [CW-1:0] ybot;
    logic signed [CW-1:0] lo;
    logic signed [CW-1:0] hi_a;
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] xpos;
    logic signed [CW-1:0] span;
    logic               y_ok;
    logic               cols_ok;
    logic               gen;

    assign eff_col  = i_in_data.frame_start ? '0 : r_col;
    assign eff_row  = i_in_data.frame_start ? '0 : r_row;
    assign eff_done = i_in_data.frame_start ? 1'b0 : r_done;
    assign active   = !eff_done && (i_cfg.sprite_width != '0) && (i_cfg.sprite_height != '0);
    assign s_sat    = (i_cfg.scale_factor > SCALE_W'(MAX_SCALE)) ?
                      SCALE_W'(MAX_SCALE) : i_cfg.scale_factor;
    assign hs       = CW'(i_cfg.sprite_height) * CW'(s_sat);
    assign rs       = CW'(eff_row) * CW'(s_sat);
    assign cs       = CW'(eff_col) * CW'(s_sat);
    assign xoff_ext = {{(CW-XOFF_W){i_cfg.x_offset[XOFF_W-1]}}, i_cfg.x_offset};

    assign s_m1    = {{(CW-SCALE_W){1'b0}}, r_a_scale - SCALE_W'(1)};
    assign ybot    = r_a_y0 + s_m1;
    assign y_ok    = (r_a_y0 >= 0) && (ybot < H_S);
    assign lo      = (r_a_x0 < 0) ? -r_a_x0 : '0;
    assign xpos    = (r_a_x0 < 0) ? '0 : r_a_x0;
    assign hi_a    = W_M1 - r_a_x0;
    assign hi      = (hi_a < s_m1) ? hi_a : s_m1;
    assign cols_ok = (lo <= hi);
    assign span    = hi - lo;
    assign gen     = r_a_gen && y_ok && cols_ok;

    assign a_adv       = !gen || i_job_ready;
    assign o_in_ready  = !r_a_valid || a_adv;
    assign accept      = i_in_valid && o_in_ready;
    assign o_job_valid = r_a_valid && gen;

    always_comb begin
        o_job.addr  = ADDR_W'(unsigned'(r_a_y0)) * W_A + ADDR_W'(unsigned'(xpos));
        o_job.color = r_a_color;
        o_job.scale = r_a_scale;
        o_job.ncols = NCOL_W'(span) + NCOL_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_done    <= 1'b0;
            r_a_valid <= 1'b0;
            r_a_gen   <= 1'b0;
        end else begin
            if (accept) begin
                r_a_valid <= 1'b1;
                r_a_gen   <= active && (s_sat != '0);
                r_a_y0    <= CW'(DEST_HEIGHT - BOTTOM_MARGIN) - hs + rs;
                r_a_x0    <= xoff_ext + cs;
                r_a_color <= i_in_data.pixel_bit ? i_cfg.fg_color : i_cfg.bg_color;
                r_a_scale <= s_sat;
                if (active) begin
                    if ({1'b0, eff_col} + (SW_W+1)'(1) >= {1'b0, i_cfg.sprite_width}) begin
                        r_col <= '0;
                        if ({1'b0, eff_row} + (SH_W+1)'(1) >=
                            {1'b0, i_cfg.sprite_height}) begin
                            r_row  <= '0;
                            r_done <= 1'b1;
                        end else begin
                            r_row  <= eff_row + SH_W'(1);
                            r_done <= 1'b0;
                        end
                    end else begin
                        r_col  <= eff_col + SW_W'(1);
                        r_row  <= eff_row;
                        r_done <= 1'b0;
                    end
                end else begin
                    r_col  <= eff_col;
                    r_row  <= eff_row;
                    r_done <= eff_done;
                end
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

@@ design/smsb_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smsb_queue
// Short request queue between the placement front and the write sequencer.
// ----------------------------------------------------------------------------
module smsb_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire smsb_pkg::t_job i_push_job,
    output logic                o_ready,
    output logic                o_valid,
    output smsb_pkg::t_job      o_job,
    input  wire logic           i_pop
);
    import smsb_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [PW:0]   r_count;
    logic          do_push;
    logic          do_pop;

    assign o_ready = (r_count != (PW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (PW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (PW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ design/smsb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smsb_back
// Walks each square row by row, column by column; one write per ready cycle.
// ----------------------------------------------------------------------------
module smsb_back #(
    parameter int DEST_WIDTH = 320
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire smsb_pkg::t_job i_job,
    output logic                o_job_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output smsb_pkg::t_pixel_out o_out_data
);
    import smsb_pkg::*;

    localparam logic [ADDR_W-1:0] W_A = ADDR_W'(DEST_WIDTH);

    logic              r_busy;
    t_job              r_job;
    logic [CNT_W-1:0]  r_r;
    logic [CNT_W-1:0]  r_c;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_row_addr;
    logic              emit;
    logic              c_last;
    logic              r_last;
    logic              last;
    logic              load;

    assign emit      = r_busy && (!o_out_valid || i_out_ready);
    assign c_last    = (NCOL_W'(r_c) + NCOL_W'(1) == r_job.ncols);
    assign r_last    = (SCALE_W'(r_r) + SCALE_W'(1) == r_job.scale);
    assign last      = c_last && r_last;
    assign load      = i_job_valid && (!r_busy || (emit && last));
    assign o_job_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                o_out_valid            <= 1'b1;
                o_out_data.pixel_addr  <= r_addr;
                o_out_data.pixel_color <= r_job.color;
                o_out_data.last_write  <= last;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            if (load) begin
                r_busy     <= 1'b1;
                r_job      <= i_job;
                r_r        <= '0;
                r_c        <= '0;
                r_addr     <= i_job.addr;
                r_row_addr <= i_job.addr;
            end else if (emit) begin
                if (last) begin
                    r_busy <= 1'b0;
                end else if (c_last) begin
                    r_c        <= '0;
                    r_r        <= r_r + CNT_W'(1);
                    r_row_addr <= r_row_addr + W_A;
                    r_addr     <= r_row_addr + W_A;
                end else begin
                    r_c    <= r_c + CNT_W'(1);
                    r_addr <= r_addr + ADDR_W'(1);
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_row_in_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (SCALE_W'(r_r) < r_job.scale))
        else $error("row counter past square height");
    a_col_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (NCOL_W'(r_c) < r_job.ncols))
        else $error("column counter past clipped span");
    a_span_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_job.ncols != '0 && r_job.ncols <= r_job.scale))
        else $error("clipped span wider than square");
`endif

endmodule
`default_nettype wire
